// ===== sv/tlnce_pkg.sv =====
// Shared types and constants for the text line numbering / caret escape unit.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package tlnce_pkg;

  localparam int DEFAULT_DIGITS      = 6;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 2;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_MODE   = 3'd0,
    REG_SHOW_ENDS     = 3'd1,
    REG_SHOW_TABS     = 3'd2,
    REG_SHOW_CONTROLS = 3'd3,
    REG_SQUEEZE_BLANK = 3'd4
  } cfg_reg_t;

  // Numbering modes
  localparam logic [1:0] NUM_NONE     = 2'd0;
  localparam logic [1:0] NUM_ALL      = 2'd1;
  localparam logic [1:0] NUM_NONBLANK = 2'd2;

  // Character codes
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_VT       = 8'h0B;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_I        = 8'h49;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CTRL_LIMIT  = 8'h20;
  localparam logic [7:0] CARET_SHIFT = 8'h40;

  localparam logic [3:0] BCD_NINE = 4'd9;

  // Bytes that follow an optional line number: one or two of them
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } tail_t;

  localparam int TAIL_W = $bits(tail_t);

endpackage

`default_nettype wire

// ===== sv/tlnce_front.sv =====
// Front end: configuration registers, line state, line counter and byte classification.
// Turns each accepted byte into a job (optional number plus tail bytes); uses tlnce_pkg.
`default_nettype none

module tlnce_front
  import tlnce_pkg::*;
#(
  parameter int NUMBER_DIGITS = DEFAULT_DIGITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                       accept,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       file_start,
  output logic                            enq,
  output logic                            job_has_num,
  output logic [4*NUMBER_DIGITS-1:0]      job_num,
  output tail_t                           job_tail
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;

  logic [1:0] number_mode_r;
  logic       show_ends_r;
  logic       show_tabs_r;
  logic       show_controls_r;
  logic       squeeze_blank_r;

  logic             prev_newline_r, prev_newline_nxt;
  logic [1:0]       blank_run_r, blank_run_nxt;
  logic             line_open_r, line_open_nxt;
  logic             number_done_r, number_done_nxt;
  logic [BCD_W-1:0] count_r, count_nxt;

  logic             drop;
  logic             is_nl;
  logic             is_space;
  logic             all_nines;
  logic             carry;
  logic [3:0]       dig;
  logic [BCD_W-1:0] bumped;

  assign is_nl    = (data_byte == CH_NL);
  assign is_space = (data_byte == CH_SPACE) || (data_byte == CH_TAB) || is_nl ||
                    (data_byte == CH_VT) || (data_byte == CH_FF) || (data_byte == CH_CR);

  // Saturating BCD increment
  always_comb begin
    all_nines = 1'b1;
    carry     = 1'b1;
    bumped    = count_r;
    for (int d = 0; d < NUMBER_DIGITS; d++) begin
      dig = count_r[4*d +: 4];
      if (dig != BCD_NINE) all_nines = 1'b0;
      if (carry) begin
        if (dig >= BCD_NINE) begin
          bumped[4*d +: 4] = 4'd0;
        end else begin
          bumped[4*d +: 4] = dig + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all_nines) bumped = count_r;
  end

  always_comb begin
    prev_newline_nxt = file_start ? 1'b1 : prev_newline_r;
    blank_run_nxt    = file_start ? 2'd0 : blank_run_r;
    line_open_nxt    = file_start ? 1'b0 : line_open_r;
    number_done_nxt  = file_start ? 1'b0 : number_done_r;
    count_nxt        = count_r;
    drop             = 1'b0;
    job_has_num      = 1'b0;

    if (squeeze_blank_r) begin
      if (is_nl && prev_newline_nxt) begin
        if (blank_run_nxt != 2'd3) blank_run_nxt = blank_run_nxt + 2'd1;
        if (blank_run_nxt > 2'd1) drop = 1'b1;
      end else begin
        blank_run_nxt = 2'd0;
      end
    end

    if (!drop) begin
      if (prev_newline_nxt) begin
        line_open_nxt   = 1'b1;
        number_done_nxt = 1'b0;
        if (number_mode_r == NUM_ALL) job_has_num = 1'b1;
      end
      if (number_mode_r == NUM_NONBLANK && !number_done_nxt && line_open_nxt && !is_space)
        job_has_num = 1'b1;
      if (job_has_num) begin
        number_done_nxt = 1'b1;
        count_nxt       = bumped;
      end
      if (is_nl) line_open_nxt = 1'b0;
      prev_newline_nxt = is_nl;
    end
  end

  assign job_num = count_nxt;
  assign enq     = accept && !drop;

  // Tail bytes: newline with optional marker, caret pairs, or the byte as is
  always_comb begin
    job_tail.two = 1'b0;
    job_tail.b0  = data_byte;
    job_tail.b1  = CH_NL;
    if (is_nl) begin
      if (show_ends_r) begin
        job_tail.two = 1'b1;
        job_tail.b0  = CH_DOLLAR;
        job_tail.b1  = CH_NL;
      end else begin
        job_tail.b0 = CH_NL;
      end
    end else if (data_byte == CH_TAB && show_tabs_r) begin
      job_tail.two = 1'b1;
      job_tail.b0  = CH_CARET;
      job_tail.b1  = CH_I;
    end else if (show_controls_r && (data_byte < CTRL_LIMIT || data_byte == CH_DEL) &&
                 data_byte != CH_TAB) begin
      job_tail.two = 1'b1;
      job_tail.b0  = CH_CARET;
      job_tail.b1  = (data_byte < CTRL_LIMIT) ? (data_byte + CARET_SHIFT) : CH_QMARK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_mode_r   <= NUM_NONE;
      show_ends_r     <= 1'b0;
      show_tabs_r     <= 1'b0;
      show_controls_r <= 1'b0;
      squeeze_blank_r <= 1'b0;
      prev_newline_r  <= 1'b1;
      blank_run_r     <= 2'd0;
      line_open_r     <= 1'b0;
      number_done_r   <= 1'b0;
      count_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_NUMBER_MODE:   number_mode_r   <= cfg_data;
          REG_SHOW_ENDS:     show_ends_r     <= cfg_data[0];
          REG_SHOW_TABS:     show_tabs_r     <= cfg_data[0];
          REG_SHOW_CONTROLS: show_controls_r <= cfg_data[0];
          REG_SQUEEZE_BLANK: squeeze_blank_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        prev_newline_r <= prev_newline_nxt;
        blank_run_r    <= blank_run_nxt;
        line_open_r    <= line_open_nxt;
        number_done_r  <= number_done_nxt;
        count_r        <= count_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tlnce_queue.sv =====
// Short register queue that decouples the front end from the back end.
// Generic width and depth; uses tlnce_pkg for the default depth.
`default_nettype none

module tlnce_queue
  import tlnce_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  q_empty,
  output logic                  q_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr, do_rd;

  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == FULL_CNT);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) entries_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      if (do_rd) rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/tlnce_back.sv =====
// Back end: expands one job into output bytes, one beat per cycle while pop is high.
// Holds the job on the result ports until every byte is popped; uses tlnce_pkg.
`default_nettype none

module tlnce_back
  import tlnce_pkg::*;
#(
  parameter int NUMBER_DIGITS = DEFAULT_DIGITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  input  wire logic                   job_has_num,
  input  wire logic [4*NUMBER_DIGITS-1:0] job_num,
  input  wire tail_t                  job_tail,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [7:0]                  out_byte,
  output logic                        out_last_of_run
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam int IW    = $clog2(NUMBER_DIGITS + 3);
  localparam logic [IW-1:0] DIGITS_I   = IW'(NUMBER_DIGITS);
  localparam logic [IW-1:0] LAST_DIG_I = IW'(NUMBER_DIGITS - 1);
  localparam logic [IW-1:0] TAIL_OFF   = IW'(NUMBER_DIGITS + 1);

  logic             cur_v_r;
  logic             has_num_r;
  logic [BCD_W-1:0] num_r;
  tail_t            tail_r;
  logic [IW-1:0]    idx_r;
  logic             lead_r;

  logic [IW-1:0] off;
  logic [3:0]    top_dig;
  logic          in_digits;
  logic          load;

  assign off       = has_num_r ? TAIL_OFF : '0;
  assign top_dig   = num_r[BCD_W-1 -: 4];
  assign in_digits = has_num_r && (idx_r < DIGITS_I);

  always_comb begin
    if (in_digits) begin
      if (lead_r && top_dig == 4'd0 && idx_r != LAST_DIG_I) out_byte = CH_SPACE;
      else out_byte = CH_ZERO | {4'd0, top_dig};
    end else if (has_num_r && idx_r == DIGITS_I) begin
      out_byte = CH_TAB;
    end else begin
      out_byte = (idx_r == off) ? tail_r.b0 : tail_r.b1;
    end
  end

  assign out_last_of_run = tail_r.two ? (idx_r == off + IW'(1)) : (idx_r == off);
  assign empty           = !cur_v_r;

  // Take a new job when idle or when the final beat of this one leaves
  assign load  = !cur_v_r || (pop && out_last_of_run);
  assign q_pop = load && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= '0;
      lead_r  <= 1'b1;
    end else if (load) begin
      cur_v_r <= !q_empty;
      idx_r   <= '0;
      lead_r  <= 1'b1;
    end else if (pop) begin
      idx_r <= idx_r + IW'(1);
      if (in_digits && top_dig != 4'd0) lead_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      has_num_r <= job_has_num;
      num_r     <= job_num;
      tail_r    <= job_tail;
    end else if (pop && in_digits) begin
      num_r <= num_r << 4;
    end
  end

endmodule

`default_nettype wire

// ===== sv/text_line_number_caret_escape_unit.sv =====
// Top level of the text line numbering and caret escape unit.
// Instantiates tlnce_front, tlnce_queue and tlnce_back; uses tlnce_pkg.
`default_nettype none

// A cat-style text filter. Push one byte per beat with in_file_start high on
// the first byte of each file; pop the filtered bytes, with out_last_of_run
// high on the final byte produced by each input byte. A squeezed empty line
// produces nothing. Numbers are NUMBER_DIGITS digits, right-justified, then a
// tab; the line count carries on across files and holds at all nines.
// Rate: the front end classifies one input byte per cycle while full is low and
// writes a job into a QUEUE_DEPTH-entry queue; the back end drives one output
// byte per cycle while the consumer pops. An input byte expands to one output
// byte for plain text, two for caret pairs or a marked line end, and up to
// NUMBER_DIGITS + 3 when a line number is written. A byte pushed into an idle
// unit passes through a queue entry and the back-end job registers before it
// shows on the result ports. The back-end expansion sets the sustained rate;
// full rises only when the queue fills behind a long expansion or a stalled
// consumer. Configuration writes through cfg_we / cfg_index / cfg_data take
// effect on the next cycle and must be made while the unit is idle.
module text_line_number_caret_escape_unit
  import tlnce_pkg::*;
#(
  parameter int NUMBER_DIGITS = DEFAULT_DIGITS,
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input queue side
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [7:0]             in_data_byte,
  input  wire logic                   in_file_start,
  // result queue side
  output logic                        empty,
  input  wire logic                   pop,
  output logic [7:0]                  out_byte,
  output logic                        out_last_of_run
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam int JOB_W = 1 + BCD_W + TAIL_W;

  logic             accept;
  logic             enq;
  logic             f_has_num;
  logic [BCD_W-1:0] f_num;
  tail_t            f_tail;

  logic [JOB_W-1:0] q_rd_data;
  logic             q_empty;
  logic             q_pop;

  logic             b_has_num;
  logic [BCD_W-1:0] b_num;
  tail_t            b_tail;

  // A beat is taken whenever the queue has room; squeezed bytes update
  // line state but write no job
  assign accept = push && !full;

  tlnce_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .file_start  (in_file_start),
    .enq         (enq),
    .job_has_num (f_has_num),
    .job_num     (f_num),
    .job_tail    (f_tail)
  );

  // Hold jobs until the back end is free
  tlnce_queue #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (enq),
    .wr_data ({f_has_num, f_num, f_tail}),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .q_empty (q_empty),
    .q_full  (full)
  );

  assign {b_has_num, b_num, b_tail} = q_rd_data;

  // Expand each job into output beats
  tlnce_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .job_has_num     (b_has_num),
    .job_num         (b_num),
    .job_tail        (b_tail),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire
